@@ design/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies; take in with `include before use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, sampled on the rising clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ design/ldss_pkg.sv @@
// shared types, widths and codes of the led driver serial sequencer
// no dependencies; compiled before every other file of the block
package ldss_pkg;

    // item fields
    localparam int OP_W  = 3;
    localparam int CH_W  = 4;
    localparam int VAL_W = 12;

    // channel stores
    localparam int CHANNELS = 16;
    localparam int GS_W     = 12;
    localparam int DC_W     = 6;
    localparam logic [GS_W-1:0] GS_RESET = '0;
    localparam logic [DC_W-1:0] DC_RESET = '1;

    // bit position within a word, grayscale clock counter
    localparam int POS_W     = 4;
    localparam int GS_TICK_W = 12;

    // default number of chained driver chips
    localparam int CHIPS_DEF = 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_GS    = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_DC    = 3'd2;
    localparam logic [OP_W-1:0] OP_START_DC = 3'd3;
    localparam logic [OP_W-1:0] OP_START_GS = 3'd4;

    // sequencer phases
    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PH_W-1:0] PH_DC_SHIFT = 3'd1;
    localparam logic [PH_W-1:0] PH_DC_LATCH = 3'd2;
    localparam logic [PH_W-1:0] PH_GS_RUN   = 3'd3;
    localparam logic [PH_W-1:0] PH_GS_LATCH = 3'd4;
    localparam logic [PH_W-1:0] PH_GS_EXTRA = 3'd5;

    // one result beat
    typedef struct packed {
        logic serial_data;
        logic shift_clock;
        logic gray_clock;
        logic latch;
        logic blank_level;
        logic program_mode;
        logic dc_source;
        logic busy_res;
    } res_t;

endpackage

@@ design/ldss_if.sv @@
// valid/ready channel interfaces for item and result beats
// depends on ldss_pkg for field widths
interface ldss_item_if
    import ldss_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [CH_W-1:0]  channel;
    logic [VAL_W-1:0] value;

    modport source (output valid, output operation, output channel, output value,
                    input ready);
    modport sink   (input valid, input operation, input channel, input value,
                    output ready);
endinterface

interface ldss_res_if;
    logic valid;
    logic ready;
    logic serial_data;
    logic shift_clock;
    logic gray_clock;
    logic latch;
    logic blank_level;
    logic program_mode;
    logic dc_source;
    logic busy_res;

    modport source (output valid, output serial_data, output shift_clock,
                    output gray_clock, output latch, output blank_level,
                    output program_mode, output dc_source, output busy_res,
                    input ready);
    modport sink   (input valid, input serial_data, input shift_clock,
                    input gray_clock, input latch, input blank_level,
                    input program_mode, input dc_source, input busy_res,
                    output ready);
endinterface

@@ design/led_driver_serial_sequencer_unit.sv @@
// top level of the led driver serial sequencer: handshake, stores, control
// depends on ldss_pkg, ldss_if, ldss_store and ldss_ctrl
//
//   channel   direction  beat contents
//   items     in         operation, channel, value
//   results   out        serial_data .. busy_res, one beat per item
//
// for each item the accept edge reads the channel stores, and
// the next edge runs the sequencer step on the registered word.
// results sit in an output register; a new item is taken in the cycle
// the previous result is taken. reset clears the stores to their reset
// words through written marks, so there is no clearing pass.
module led_driver_serial_sequencer_unit
    import ldss_pkg::*;
#(
    parameter int CHIPS = CHIPS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    ldss_item_if.sink    items,
    ldss_res_if.source   results
);

    logic            accept;
    logic            pend_reg,      pend_next;
    logic [OP_W-1:0] op_reg,        op_next;
    logic            out_valid_reg, out_valid_next;
    res_t            res_reg;
    res_t            res_step;
    logic [CH_W-1:0] rd_addr;
    logic [GS_W-1:0] gray_word;
    logic [DC_W-1:0] dot_word;
    logic            gray_we;
    logic            dot_we;

    // input handshake: one item in flight, output register free by then
    assign items.ready = !pend_reg && (!out_valid_reg || results.ready);
    assign accept      = items.valid && items.ready;
    assign gray_we     = accept && (items.operation == OP_WR_GS);
    assign dot_we      = accept && (items.operation == OP_WR_DC);

    // channel stores
    ldss_store #(
        .W       (GS_W),
        .RST_VAL (GS_RESET)
    ) u_gray (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (gray_we),
        .waddr (items.channel),
        .wdata (items.value),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (gray_word)
    );

    ldss_store #(
        .W       (DC_W),
        .RST_VAL (DC_RESET)
    ) u_dot (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (dot_we),
        .waddr (items.channel),
        .wdata (items.value[DC_W-1:0]),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (dot_word)
    );

    // sequencer step
    ldss_ctrl #(
        .CHIPS (CHIPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .exec      (pend_reg),
        .op        (op_reg),
        .gray_word (gray_word),
        .dot_word  (dot_word),
        .rd_addr   (rd_addr),
        .res       (res_step)
    );

    // pending item and output beat control
    always_comb
    begin
        pend_next      = accept;
        op_next        = accept ? items.operation : op_reg;
        out_valid_next = out_valid_reg;
        if (pend_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            op_reg        <= OP_TICK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            res_reg <= res_step;
        end
    end

    // output beat
    assign results.valid        = out_valid_reg;
    assign results.serial_data  = res_reg.serial_data;
    assign results.shift_clock  = res_reg.shift_clock;
    assign results.gray_clock   = res_reg.gray_clock;
    assign results.latch        = res_reg.latch;
    assign results.blank_level  = res_reg.blank_level;
    assign results.program_mode = res_reg.program_mode;
    assign results.dc_source    = res_reg.dc_source;
    assign results.busy_res     = res_reg.busy_res;

endmodule

@@ design/ldss_store.sv @@
// per-channel word store: synchronous ram with registered read
// entries never written read as the reset word; depends on ldss_pkg
module ldss_store
    import ldss_pkg::*;
#(
    parameter int            W       = GS_W,
    parameter logic [W-1:0]  RST_VAL = '0
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            we,
    input  logic [CH_W-1:0] waddr,
    input  logic [W-1:0]    wdata,
    input  logic            re,
    input  logic [CH_W-1:0] raddr,
    output logic [W-1:0]    rdata
);

    logic [W-1:0]        mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;
    logic [W-1:0]        rd_data_reg;
    logic                rd_valid_reg;

    // memory array write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // written marks, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    // unwritten entries give the reset word
    assign rdata = rd_valid_reg ? rd_data_reg : RST_VAL;

endmodule

@@ design/ldss_ctrl.sv @@
// sequencer control: phase machine, shift position and pin line levels
// depends on ldss_pkg; word data comes from the two ldss_store instances
module ldss_ctrl
    import ldss_pkg::*;
#(
    parameter int CHIPS = CHIPS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            exec,
    input  logic [OP_W-1:0] op,
    input  logic [GS_W-1:0] gray_word,
    input  logic [DC_W-1:0] dot_word,
    output logic [CH_W-1:0] rd_addr,
    output res_t            res
);

    localparam int CHIP_W = (CHIPS > 1) ? $clog2(CHIPS) : 1;
    localparam logic [CHIP_W-1:0] CHIP_LAST = CHIP_W'(CHIPS - 1);

    logic [PH_W-1:0]      phase_reg,  phase_next;
    logic [CH_W-1:0]      ch_reg,     ch_next;
    logic [POS_W-1:0]     pos_reg,    pos_next;
    logic [CHIP_W-1:0]    chip_reg,   chip_next;
    logic                 done_reg,   done_next;
    logic [GS_TICK_W-1:0] tick_reg,   tick_next;
    logic                 first_reg,  first_next;
    logic                 mode_reg,   mode_next;
    logic                 source_reg, source_next;
    logic                 blank_reg,  blank_next;

    logic [POS_W-1:0] pos_top;
    logic             shift_last;

    // next word is read at the current channel position
    assign rd_addr    = ch_reg;
    assign pos_top    = (phase_reg == PH_GS_RUN) ? POS_W'(GS_W - 1) : POS_W'(DC_W - 1);
    assign shift_last = (pos_reg == '0) && (ch_reg == '0) && (chip_reg == CHIP_LAST);

    // step of the sequence for one executed beat
    always_comb
    begin
        phase_next  = phase_reg;
        ch_next     = ch_reg;
        pos_next    = pos_reg;
        chip_next   = chip_reg;
        done_next   = done_reg;
        tick_next   = tick_reg;
        first_next  = first_reg;
        mode_next   = mode_reg;
        source_next = source_reg;
        blank_next  = blank_reg;
        res         = '0;

        if (exec)
        begin
            case (op)
                OP_TICK:
                begin
                    case (phase_reg)
                        PH_DC_SHIFT:
                        begin
                            res.serial_data = dot_word[pos_reg[2:0]];
                            res.shift_clock = 1'b1;
                            if (shift_last)
                            begin
                                phase_next = PH_DC_LATCH;
                            end
                        end
                        PH_DC_LATCH:
                        begin
                            res.latch  = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        PH_GS_RUN:
                        begin
                            if (!done_reg)
                            begin
                                res.serial_data = gray_word[pos_reg];
                                res.shift_clock = 1'b1;
                                done_next       = shift_last;
                            end
                            res.gray_clock = 1'b1;
                            tick_next      = tick_reg + 1'b1;
                            if (tick_reg == '1)
                            begin
                                phase_next = PH_GS_LATCH;
                            end
                        end
                        PH_GS_LATCH:
                        begin
                            blank_next = 1'b1;
                            res.latch  = 1'b1;
                            phase_next = first_reg ? PH_GS_EXTRA : PH_IDLE;
                        end
                        PH_GS_EXTRA:
                        begin
                            res.shift_clock = 1'b1;
                            first_next      = 1'b0;
                            phase_next      = PH_IDLE;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase

                    // walk the bit position after a shift beat, but not after the trailing one
                    if (res.shift_clock && (phase_reg != PH_GS_EXTRA))
                    begin
                        if (pos_reg == '0)
                        begin
                            pos_next = pos_top;
                            ch_next  = ch_reg - 1'b1;
                            if (ch_reg == '0)
                            begin
                                chip_next = chip_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            pos_next = pos_reg - 1'b1;
                        end
                    end
                end
                OP_START_DC:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        source_next = 1'b1;
                        mode_next   = 1'b1;
                        ch_next     = '1;
                        pos_next    = POS_W'(DC_W - 1);
                        chip_next   = '0;
                        phase_next  = PH_DC_SHIFT;
                    end
                end
                OP_START_GS:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        first_next = mode_reg;
                        mode_next  = 1'b0;
                        blank_next = 1'b0;
                        ch_next    = '1;
                        pos_next   = POS_W'(GS_W - 1);
                        chip_next  = '0;
                        done_next  = 1'b0;
                        tick_next  = '0;
                        phase_next = PH_GS_RUN;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        res.blank_level  = blank_next;
        res.program_mode = mode_next;
        res.dc_source    = source_next;
        res.busy_res     = (phase_next != PH_IDLE);
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            ch_reg     <= '1;
            pos_reg    <= '0;
            chip_reg   <= '0;
            done_reg   <= 1'b0;
            tick_reg   <= '0;
            first_reg  <= 1'b0;
            mode_reg   <= 1'b1;
            source_reg <= 1'b0;
            blank_reg  <= 1'b1;
        end
        else
        begin
            phase_reg  <= phase_next;
            ch_reg     <= ch_next;
            pos_reg    <= pos_next;
            chip_reg   <= chip_next;
            done_reg   <= done_next;
            tick_reg   <= tick_next;
            first_reg  <= first_next;
            mode_reg   <= mode_next;
            source_reg <= source_next;
            blank_reg  <= blank_next;
        end
    end

endmodule

@@ design/ldss_checker.sv @@
// port-level checks of the led driver serial sequencer, bound to the top
// depends on assert_macros.svh
`include "assert_macros.svh"

module ldss_checker
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic serial_data,
    input logic shift_clock,
    input logic gray_clock,
    input logic latch,
    input logic blank_level,
    input logic program_mode,
    input logic dc_source,
    input logic busy_res
);

    // grayscale clock and latch never share a beat
    `ASSERT_IMPLY(a_gck_no_latch, clk, rst_n, out_valid && gray_clock, !latch)

    // grayscale clock only runs unblanked in grayscale mode while busy
    `ASSERT_IMPLY(a_gck_mode, clk, rst_n, out_valid && gray_clock,
                  busy_res && !blank_level && !program_mode)

    // outputs are blanked whenever no sequence runs
    `ASSERT_IMPLY(a_idle_blank, clk, rst_n, out_valid && !busy_res, blank_level)

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                 out_valid && $stable(serial_data) && $stable(shift_clock)
                 && $stable(gray_clock) && $stable(latch) && $stable(blank_level)
                 && $stable(program_mode) && $stable(dc_source) && $stable(busy_res))

endmodule

bind led_driver_serial_sequencer_unit ldss_checker u_ldss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .serial_data  (results.serial_data),
    .shift_clock  (results.shift_clock),
    .gray_clock   (results.gray_clock),
    .latch        (results.latch),
    .blank_level  (results.blank_level),
    .program_mode (results.program_mode),
    .dc_source    (results.dc_source),
    .busy_res     (results.busy_res)
);

@@ bench/led_driver_serial_sequencer_unit_tb.sv @@
// self-checking bench for the led driver serial sequencer: directed table, then random sessions
// depends on ldss_pkg, the ldss_if interfaces and led_driver_serial_sequencer_unit
module led_driver_serial_sequencer_unit_tb
    import ldss_pkg::*;
();

    localparam int CHIPS        = CHIPS_DEF;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 1350;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 2000000;

    // pin sequence lengths
    localparam int DC_BITS  = 96;
    localparam int GS_BITS  = 192;
    localparam int GS_TICKS = 4096;

    typedef logic [OP_W-1:0]  op_t;
    typedef logic [CH_W-1:0]  ch_t;
    typedef logic [VAL_W-1:0] val_t;

    // operation codes with no function
    localparam op_t OP_RSVD_A = 3'd5;
    localparam op_t OP_RSVD_B = 3'd7;

    // fixed pin levels: sd, sck, gck, lat, blank, mode, src, busy
    localparam res_t PINS_IDLE    = 8'b0000_1100;
    localparam res_t PINS_DC_BUSY = 8'b0000_1111;
    localparam res_t PINS_DC_ONE  = 8'b1100_1111;
    localparam res_t PINS_DC_ZERO = 8'b0100_1111;

    typedef struct packed {
        op_t  op;
        ch_t  ch;
        val_t val;
        logic pinned;
        res_t want;
    } probe_row_t;

    localparam int PROBE_ROWS = 20;

    // directed table: reset levels, field extremes, spare codes, starts while busy,
    // dot-correction write during a load
    localparam probe_row_t PROBES [PROBE_ROWS] = '{
        '{OP_TICK,     4'd0,  12'd0,    1'b1, PINS_IDLE},
        '{OP_RSVD_B,   4'd15, 12'd4095, 1'b1, PINS_IDLE},
        '{OP_RSVD_A,   4'd0,  12'd0,    1'b1, PINS_IDLE},
        '{OP_WR_GS,    4'd15, 12'd4095, 1'b1, PINS_IDLE},
        '{OP_WR_GS,    4'd0,  12'd0,    1'b1, PINS_IDLE},
        '{OP_WR_GS,    4'd14, 12'h5a5,  1'b1, PINS_IDLE},
        '{OP_WR_DC,    4'd15, 12'd4095, 1'b1, PINS_IDLE},
        '{OP_WR_DC,    4'd0,  12'd0,    1'b1, PINS_IDLE},
        '{OP_WR_DC,    4'd14, 12'haaa,  1'b1, PINS_IDLE},
        '{OP_START_DC, 4'd0,  12'd0,    1'b1, PINS_DC_BUSY},
        '{OP_START_GS, 4'd3,  12'd7,    1'b1, PINS_DC_BUSY},
        '{OP_START_DC, 4'd9,  12'd1,    1'b1, PINS_DC_BUSY},
        '{OP_TICK,     4'd0,  12'd0,    1'b1, PINS_DC_ONE},
        '{OP_TICK,     4'd15, 12'd4095, 1'b1, PINS_DC_ONE},
        '{OP_WR_DC,    4'd15, 12'd0,    1'b1, PINS_DC_BUSY},
        '{OP_TICK,     4'd0,  12'd0,    1'b1, PINS_DC_ZERO},
        '{OP_TICK,     4'd0,  12'd0,    1'b1, PINS_DC_ZERO},
        '{OP_RSVD_A,   4'd8,  12'd2048, 1'b1, PINS_DC_BUSY},
        '{OP_TICK,     4'd0,  12'd0,    1'b0, '0},
        '{OP_WR_GS,    4'd7,  12'h800,  1'b0, '0}
    };

    logic clk;
    logic rst_n;

    ldss_item_if items_ch ();
    ldss_res_if  results_ch ();

    led_driver_serial_sequencer_unit #(
        .CHIPS (CHIPS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch.sink),
        .results (results_ch.source)
    );

    // predicted driver pin state
    logic [GS_W-1:0] gs_words [CHANNELS];
    logic [DC_W-1:0] dc_words [CHANNELS];
    logic [PH_W-1:0] seq_phase;
    int              shift_idx;
    logic [12:0]     gck_count;
    logic            first_q;
    logic            mode_q;
    logic            src_q;
    logic            blank_q;

    res_t pins_due [$];

    int  faults         = 0;
    int  checked_beats  = 0;
    int  fed_items      = 0;
    int  cycle_count    = 0;
    int  src_seg_left   = 0;
    bit  src_calm       = 1'b0;
    bit  no_idle        = 1'b0;
    bit  stall_req      = 1'b0;
    int  sink_hold_left = 0;

    initial clk = 1'b0;

    always
    begin
        #10 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // one pin step for one accepted item
    function automatic res_t pin_step(input op_t op, input ch_t ch, input val_t val);
        res_t p;
        int   b;
        p = '0;
        case (op)
            OP_TICK:
            begin
                case (seq_phase)
                    PH_DC_SHIFT:
                    begin
                        b = shift_idx % DC_BITS;
                        p.serial_data = dc_words[15 - b / 6][5 - b % 6];
                        p.shift_clock = 1'b1;
                        shift_idx++;
                        if (shift_idx >= DC_BITS * CHIPS)
                            seq_phase = PH_DC_LATCH;
                    end
                    PH_DC_LATCH:
                    begin
                        p.latch   = 1'b1;
                        seq_phase = PH_IDLE;
                    end
                    PH_GS_RUN:
                    begin
                        if (shift_idx < GS_BITS * CHIPS)
                        begin
                            b = shift_idx % GS_BITS;
                            p.serial_data = gs_words[15 - b / 12][11 - b % 12];
                            p.shift_clock = 1'b1;
                            shift_idx++;
                        end
                        p.gray_clock = 1'b1;
                        gck_count++;
                        if (gck_count >= GS_TICKS)
                            seq_phase = PH_GS_LATCH;
                    end
                    PH_GS_LATCH:
                    begin
                        blank_q   = 1'b1;
                        p.latch   = 1'b1;
                        seq_phase = first_q ? PH_GS_EXTRA : PH_IDLE;
                    end
                    PH_GS_EXTRA:
                    begin
                        // trailing shift clock after the first cycle, data line low
                        p.shift_clock = 1'b1;
                        first_q       = 1'b0;
                        seq_phase     = PH_IDLE;
                    end
                    default: ;
                endcase
            end
            OP_WR_GS: gs_words[ch] = val;
            OP_WR_DC: dc_words[ch] = val[DC_W-1:0];
            OP_START_DC:
            begin
                if (seq_phase == PH_IDLE)
                begin
                    src_q     = 1'b1;
                    mode_q    = 1'b1;
                    shift_idx = 0;
                    seq_phase = PH_DC_SHIFT;
                end
            end
            OP_START_GS:
            begin
                if (seq_phase == PH_IDLE)
                begin
                    first_q   = mode_q;
                    mode_q    = 1'b0;
                    blank_q   = 1'b0;
                    shift_idx = 0;
                    gck_count = '0;
                    seq_phase = PH_GS_RUN;
                end
            end
            default: ;
        endcase
        p.blank_level  = blank_q;
        p.program_mode = mode_q;
        p.dc_source    = src_q;
        p.busy_res     = (seq_phase != PH_IDLE);
        return p;
    endfunction

    // offer one item beat, wait for it to be taken, then log its pin levels
    task automatic send_beat(input op_t op, input ch_t ch, input val_t val,
                             input logic pinned, input res_t want);
        int   gap;
        res_t pins;
        gap = 0;
        if (src_seg_left == 0)
        begin
            src_seg_left = $urandom_range(50, 300);
            src_calm     = ($urandom_range(0, 2) == 0);
        end
        src_seg_left--;
        if (!no_idle && !src_calm && sink_hold_left == 0 && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            items_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_ch.valid     <= 1'b1;
        items_ch.operation <= op;
        items_ch.channel   <= ch;
        items_ch.value     <= val;
        do
            @(posedge clk);
        while (items_ch.ready !== 1'b1);
        pins = pin_step(op, ch, val);
        pins_due.push_back(pinned ? want : pins);
        if (op <= OP_START_GS)
            fed_items++;
    endtask

    // any item, random fields; starts left out when they would kick off a run
    task automatic send_noise(input bit with_starts);
        op_t op;
        do
            op = op_t'($urandom_range(0, 7));
        while (!with_starts && (op == OP_START_DC || op == OP_START_GS));
        send_beat(op, ch_t'($urandom), val_t'($urandom), 1'b0, '0);
    endtask

    // tick until the running sequence ends, with stray items mixed in
    task automatic run_to_idle();
        while (seq_phase != PH_IDLE)
        begin
            if ($urandom_range(0, 15) == 0)
                send_noise(1'b1);
            else
                send_beat(OP_TICK, ch_t'($urandom), val_t'($urandom), 1'b0, '0);
        end
    endtask

    task automatic dc_session();
        repeat ($urandom_range(0, 6))
            send_beat(OP_WR_DC, ch_t'($urandom), val_t'($urandom), 1'b0, '0);
        send_beat(OP_START_DC, ch_t'($urandom), val_t'($urandom), 1'b0, '0);
        run_to_idle();
    endtask

    task automatic gs_session();
        repeat ($urandom_range(0, 8))
            send_beat(OP_WR_GS, ch_t'($urandom), val_t'($urandom), 1'b0, '0);
        send_beat(OP_START_GS, ch_t'($urandom), val_t'($urandom), 1'b0, '0);
        run_to_idle();
    endtask

    // stimulus
    initial
    begin : stimulus
        items_ch.valid     = 1'b0;
        items_ch.operation = OP_TICK;
        items_ch.channel   = '0;
        items_ch.value     = '0;
        rst_n              = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            gs_words[i] = GS_RESET;
            dc_words[i] = DC_RESET;
        end
        seq_phase = PH_IDLE;
        shift_idx = 0;
        gck_count = '0;
        first_q   = 1'b0;
        mode_q    = 1'b1;
        src_q     = 1'b0;
        blank_q   = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < PROBE_ROWS; i++)
            send_beat(PROBES[i].op, PROBES[i].ch, PROBES[i].val,
                      PROBES[i].pinned, PROBES[i].want);

        // random part: dot-correction loads and idle noise
        fed_items = 0;
        run_to_idle();
        while (fed_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                repeat ($urandom_range(1, 8))
                    send_noise(1'b0);
            end
            else
                dc_session();
        end

        // first grayscale cycle with the mode line high, under a long result hold
        stall_req = 1'b1;
        gs_session();
        // second one starts with the mode line already low
        gs_session();

        // closing load with no idling on either side
        no_idle = 1'b1;
        dc_session();

        items_ch.valid <= 1'b0;
        while (pins_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pins_due.size() != 0)
            faults++;
        if (faults == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // result side ready: random bursts, calm stretches, one long hold
    initial
    begin : result_sink
        int gap;
        int seg_left;
        bit calm;
        gap      = 0;
        seg_left = 0;
        calm     = 1'b0;
        results_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (sink_hold_left > 0)
            begin
                sink_hold_left--;
                results_ch.ready <= 1'b0;
            end
            else if (stall_req)
            begin
                stall_req      = 1'b0;
                sink_hold_left = LONG_HOLD - 1;
                results_ch.ready <= 1'b0;
            end
            else if (no_idle)
                results_ch.ready <= 1'b1;
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(100, 400);
                    calm     = ($urandom_range(0, 2) == 0);
                end
                seg_left--;
                if (gap > 0)
                begin
                    gap--;
                    results_ch.ready <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 15) == 0)
                begin
                    gap = $urandom_range(1, 12) - 1;
                    results_ch.ready <= 1'b0;
                end
                else
                    results_ch.ready <= 1'b1;
            end
        end
    end

    // compare each result beat with the oldest predicted pin levels
    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            got = {results_ch.serial_data, results_ch.shift_clock, results_ch.gray_clock,
                   results_ch.latch, results_ch.blank_level, results_ch.program_mode,
                   results_ch.dc_source, results_ch.busy_res};
            if (pins_due.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("result beat %0d with nothing pending: %b", checked_beats, got);
            end
            else
            begin
                want = pins_due.pop_front();
                if (got !== want)
                begin
                    faults++;
                    if (faults <= 10)
                    begin
                        $write("pin mismatch at beat %0d (expected/actual): ", checked_beats);
                        $write("sd %b/%b sck %b/%b gck %b/%b lat %b/%b ",
                               want.serial_data, got.serial_data,
                               want.shift_clock, got.shift_clock,
                               want.gray_clock, got.gray_clock,
                               want.latch, got.latch);
                        $display("blank %b/%b mode %b/%b src %b/%b busy %b/%b",
                                 want.blank_level, got.blank_level,
                                 want.program_mode, got.program_mode,
                                 want.dc_source, got.dc_source,
                                 want.busy_res, got.busy_res);
                    end
                end
            end
            checked_beats++;
        end
    end

    // hang guard
    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

endmodule
